@@ rtl/bpbd_pkg.sv @@
// Shared types and constants of the band peak beat detector.
`default_nettype none

package bpbd_pkg;

    localparam int BIN_IDX_W  = 11;
    localparam int MAG_W      = 16;
    localparam int PEAK_W     = 15;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [PEAK_W-1:0]    PEAK_FULL       = 15'd16384;
    localparam logic [BIN_IDX_W-1:0] MIN_BIN_RST     = 11'd0;
    localparam logic [BIN_IDX_W-1:0] MAX_BIN_RST     = 11'd1024;
    localparam logic [MAG_W-1:0]     THRESHOLD_RST   = 16'd11469;
    localparam logic [15:0]          DEBOUNCE_RST    = 16'd100;
    localparam logic [MAG_W-1:0]     DECAY_STEP_RST  = 16'd819;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_BIN     = 3'd0,
        CFG_MAX_BIN     = 3'd1,
        CFG_THRESHOLD   = 3'd2,
        CFG_DEBOUNCE_MS = 3'd3,
        CFG_DECAY_STEP  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [BIN_IDX_W-1:0] min_bin;
        logic [BIN_IDX_W-1:0] max_bin;
        logic [MAG_W-1:0]     threshold;
        logic [15:0]          debounce_ms;
        logic [MAG_W-1:0]     decay_step;
    } t_cfg;

    typedef struct packed {
        logic [MAG_W-1:0]  bin_value;
        logic              frame_last;
        logic [TIME_W-1:0] now_ms;
    } t_in_beat;

    typedef struct packed {
        logic [MAG_W-1:0]  band_level;
        logic              beat;
        logic [PEAK_W-1:0] peak_env;
        logic [MAG_W-1:0]  smooth_level;
        logic [TIME_W-1:0] ms_since_beat;
    } t_out_beat;

    // Control from the input register stage to the per-bin and per-frame logic.
    typedef struct packed {
        logic advance;
        logic frame_last;
    } t_stage_ctl;

endpackage

`default_nettype wire

@@ rtl/bpbd_in_if.sv @@
// Valid/ready channel carrying spectrum bin beats.
`default_nettype none

interface bpbd_in_if
    import bpbd_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_beat payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/bpbd_out_if.sv @@
// Valid/ready channel carrying per-frame result beats.
`default_nettype none

interface bpbd_out_if
    import bpbd_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_beat payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/bpbd_cfg_regs.sv @@
// Configuration register file of the beat detector.
`default_nettype none

module bpbd_cfg_regs
    import bpbd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_bin     <= MIN_BIN_RST;
            r_cfg.max_bin     <= MAX_BIN_RST;
            r_cfg.threshold   <= THRESHOLD_RST;
            r_cfg.debounce_ms <= DEBOUNCE_RST;
            r_cfg.decay_step  <= DECAY_STEP_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MIN_BIN:     r_cfg.min_bin     <= i_cfg_data[BIN_IDX_W-1:0];
                CFG_MAX_BIN:     r_cfg.max_bin     <= i_cfg_data[BIN_IDX_W-1:0];
                CFG_THRESHOLD:   r_cfg.threshold   <= i_cfg_data[MAG_W-1:0];
                CFG_DEBOUNCE_MS: r_cfg.debounce_ms <= i_cfg_data[15:0];
                CFG_DECAY_STEP:  r_cfg.decay_step  <= i_cfg_data[MAG_W-1:0];
                default: begin
                    // Unused indexes are ignored.
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/bpbd_band_max.sv @@
// Bin position counter and in-band running maximum.
`default_nettype none

module bpbd_band_max
    import bpbd_pkg::*;
#(
    parameter int NUM_BINS = 1024
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_stage_ctl       i_ctl,
    input  wire logic [MAG_W-1:0] i_bin_value,
    input  wire t_cfg             i_cfg,
    output logic      [MAG_W-1:0] o_level
);

    localparam int CNT_W = $clog2(NUM_BINS + 1);
    localparam int CMP_W = (CNT_W > BIN_IDX_W) ? CNT_W : BIN_IDX_W;

    logic [CNT_W-1:0] r_bin_cnt, n_bin_cnt;
    logic [MAG_W-1:0] r_run_max, n_run_max;

    logic [BIN_IDX_W-1:0] band_lo, band_hi;
    logic [CMP_W-1:0]     cnt_ext, lo_ext, hi_ext;
    logic                 cnt_full, in_band;

    always_comb begin
        // A swapped pair of bounds still describes [smaller, larger).
        if (i_cfg.min_bin < i_cfg.max_bin) begin
            band_lo = i_cfg.min_bin;
            band_hi = i_cfg.max_bin;
        end else begin
            band_lo = i_cfg.max_bin;
            band_hi = i_cfg.min_bin;
        end
        cnt_ext  = CMP_W'(r_bin_cnt);
        lo_ext   = CMP_W'(band_lo);
        hi_ext   = CMP_W'(band_hi);
        cnt_full = (r_bin_cnt == CNT_W'(NUM_BINS));
        in_band  = !cnt_full && (cnt_ext >= lo_ext) && (cnt_ext < hi_ext);

        o_level = (in_band && (i_bin_value > r_run_max)) ? i_bin_value : r_run_max;

        n_bin_cnt = r_bin_cnt;
        n_run_max = r_run_max;
        if (i_ctl.advance) begin
            if (i_ctl.frame_last) begin
                n_bin_cnt = '0;
                n_run_max = '0;
            end else begin
                n_run_max = o_level;
                if (!cnt_full) begin
                    n_bin_cnt = r_bin_cnt + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_cnt <= '0;
            r_run_max <= '0;
        end else begin
            r_bin_cnt <= n_bin_cnt;
            r_run_max <= n_run_max;
        end
    end

endmodule

`default_nettype wire

@@ rtl/bpbd_env_update.sv @@
// Per-frame beat decision, envelope state and result register.
`default_nettype none

module bpbd_env_update
    import bpbd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_stage_ctl        i_ctl,
    input  wire logic [MAG_W-1:0]  i_level,
    input  wire logic [TIME_W-1:0] i_now_ms,
    input  wire t_cfg              i_cfg,
    output t_out_beat              o_res,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready
);

    logic [PEAK_W-1:0] r_peak, n_peak;
    logic [MAG_W-1:0]  r_smooth, n_smooth;
    logic [TIME_W-1:0] r_last_time, n_last_time;
    logic              r_seen, n_seen;
    logic              r_res_valid, n_res_valid;
    t_out_beat         r_res, n_res;

    logic              load;
    logic [TIME_W-1:0] since;
    logic              beat;

    always_comb begin
        load  = i_ctl.advance && i_ctl.frame_last;
        since = r_seen ? (i_now_ms - r_last_time) : '1;
        beat  = (i_level > i_cfg.threshold) &&
                (!r_seen || (since > TIME_W'(i_cfg.debounce_ms)));

        n_peak      = r_peak;
        n_smooth    = r_smooth;
        n_last_time = r_last_time;
        n_seen      = r_seen;
        n_res       = r_res;
        n_res_valid = r_res_valid && !i_res_ready;

        if (load) begin
            if (beat) begin
                n_peak      = PEAK_FULL;
                n_last_time = i_now_ms;
                n_seen      = 1'b1;
            end else if ({1'b0, r_peak} > i_cfg.decay_step) begin
                n_peak = r_peak - PEAK_W'(i_cfg.decay_step);
            end else begin
                n_peak = '0;
            end

            if (i_level > r_smooth) begin
                n_smooth = i_level;
            end else if (r_smooth > i_cfg.decay_step) begin
                n_smooth = r_smooth - i_cfg.decay_step;
            end else begin
                n_smooth = '0;
            end

            n_res.band_level    = i_level;
            n_res.beat          = beat;
            n_res.peak_env      = n_peak;
            n_res.smooth_level  = n_smooth;
            n_res.ms_since_beat = since;
            n_res_valid         = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak      <= '0;
            r_smooth    <= '0;
            r_last_time <= '0;
            r_seen      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_peak      <= n_peak;
            r_smooth    <= n_smooth;
            r_last_time <= n_last_time;
            r_seen      <= n_seen;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

endmodule

`default_nettype wire

@@ rtl/band_peak_beat_detector.sv @@
// Top level of the band peak beat detector: input register, handshake and assertions.
// A final bin is held in the input register; its result then enters the result register.
// Throughput: one bin beat per cycle; bins that do not end a frame never wait on the output.
// A frame-ending bin waits in the input register only while an earlier result is not taken.
// Reset (synchronous, active low) clears all but the payload registers and loads defaults.
`default_nettype none

module band_peak_beat_detector
    import bpbd_pkg::*;
#(
    parameter int NUM_BINS = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    bpbd_in_if.sink                    i_bin_if,
    bpbd_out_if.source                 o_res_if,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // The design is two register stages deep. The input register holds one bin
    // beat; the logic behind it updates the bin counter and running maximum on
    // every beat, and on the final bin of a frame also decides the beat and
    // loads the result register. Everything between the two registers is a
    // handful of compares, one subtraction per envelope, one for elapsed time.

    t_cfg       cfg;
    t_stage_ctl stage_ctl;
    t_out_beat  res;
    logic       res_valid;
    logic [MAG_W-1:0] level;

    logic       r_in_valid;
    t_in_beat   r_in;
    logic       advance;
    logic       in_ready;

    // The input stage moves on unless it holds a frame-ending bin and the
    // result register is still full and not being drained in this cycle.
    assign advance  = r_in_valid && (!r_in.frame_last || !res_valid || o_res_if.ready);
    assign in_ready = !r_in_valid || advance;

    assign i_bin_if.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_bin_if.valid;
        end
    end

    // Payload needs no reset: it is qualified by the valid flag.
    always_ff @(posedge i_clk) begin
        if (in_ready && i_bin_if.valid) begin
            r_in <= i_bin_if.payload;
        end
    end

    always_comb begin
        stage_ctl.advance    = advance;
        stage_ctl.frame_last = r_in.frame_last;
    end

    bpbd_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bpbd_band_max #(
        .NUM_BINS (NUM_BINS)
    ) u_band_max (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (stage_ctl),
        .i_bin_value (r_in.bin_value),
        .i_cfg       (cfg),
        .o_level     (level)
    );

    bpbd_env_update u_env_update (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (stage_ctl),
        .i_level     (level),
        .i_now_ms    (r_in.now_ms),
        .i_cfg       (cfg),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_ready (o_res_if.ready)
    );

    assign o_res_if.valid   = res_valid;
    assign o_res_if.payload = res;

    // A frame-ending bin must not move on while the result register is held.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in.frame_last && res_valid && !o_res_if.ready) |-> !advance)
        else $error("result register would be overwritten while stalled");

    // A new bin beat enters only when the held one moves on or none is held.
    a_in_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_bin_if.valid && i_bin_if.ready && r_in_valid) |-> advance)
        else $error("input register overwritten before it moved on");

    // A reported beat always lies above the threshold.
    a_beat_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_if.valid && o_res_if.payload.beat) |->
            (o_res_if.payload.band_level > cfg.threshold))
        else $error("beat reported at or below threshold");

    // The peak envelope never exceeds full scale, and a beat sets it to full scale.
    a_peak_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_if.valid |-> ((o_res_if.payload.peak_env <= PEAK_FULL) &&
            (!o_res_if.payload.beat || (o_res_if.payload.peak_env == PEAK_FULL))))
        else $error("peak envelope out of range");

endmodule

`default_nettype wire
